// File: rtl/core/point_bounds_and_normalize_unit_assert.svh
// Assertion macros shared by the point bounds and normalize unit.
`ifndef POINT_BOUNDS_AND_NORMALIZE_UNIT_ASSERT_SVH
`define POINT_BOUNDS_AND_NORMALIZE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PBN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pbn_pkg.sv
// Package: types, constants and state codes of the point bounds and normalize unit.
`timescale 1ns / 1ps
package pbn_pkg;

  localparam int DEF_INDEX_BITS = 16;
  localparam int COORD_BITS     = 32;
  localparam int SCALE_BITS     = 16;
  localparam int PEAK_BITS      = 16;
  localparam int NUM_AXES       = 3;
  localparam int AXIS_BITS      = 2;
  localparam int DIV_BITS       = 32;
  localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);
  localparam int PROD_BITS      = COORD_BITS + SCALE_BITS;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] coord_vec_t;

  typedef enum logic {
    KIND_OBSERVE   = 1'b0,
    KIND_NORMALIZE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBSERVE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                   kind;
    logic                   starts_cloud;
    logic signed [31:0]     coord_x;
    logic signed [31:0]     coord_y;
    logic signed [31:0]     coord_z;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]        norm_x;
    logic [31:0]        norm_y;
    logic [31:0]        norm_z;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic [15:0]        peak_x_index;
    logic [15:0]        peak_y_index;
    logic [15:0]        peak_z_index;
  } out_beat_t;

endpackage

// File: rtl/core/pbn_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module pbn_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pbn_pkg::DIV_BITS-1:0]      num_hi_i,
  input  logic [pbn_pkg::DIV_BITS-1:0]      num_lo_i,
  input  logic [pbn_pkg::DIV_BITS-1:0]      divisor_i,
  output logic                              done_o,
  output logic [pbn_pkg::DIV_BITS-1:0]      quotient_o
);

  localparam int W  = pbn_pkg::DIV_BITS;
  localparam int CW = pbn_pkg::DIV_CNT_BITS;

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  sh_q, sh_d;
  logic [W-1:0]  div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // Bring the next dividend bit down, subtract if it fits.
  assign trial = {rem_q, sh_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_hi_i;
      sh_d   = num_lo_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      sh_d  = {sh_q[W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: rtl/core/pbn_tracker.sv
// Per-axis bounds tracker: running min, max, peak index and point count.
`timescale 1ns / 1ps
module pbn_tracker #(
  parameter int INDEX_BITS = pbn_pkg::DEF_INDEX_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         obs_i,
  input  logic                                         restart_i,
  input  pbn_pkg::coord_vec_t                          point_i,
  output pbn_pkg::coord_vec_t                          lo_o,
  output pbn_pkg::coord_vec_t                          hi_o,
  output logic [pbn_pkg::NUM_AXES-1:0][INDEX_BITS-1:0] top_o,
  output logic                                         valid_o
);

  localparam int NA = pbn_pkg::NUM_AXES;

  pbn_pkg::coord_vec_t               lo_q, lo_d, hi_q, hi_d;
  logic [NA-1:0][INDEX_BITS-1:0]     top_q, top_d;
  logic [INDEX_BITS-1:0]             count_q, count_d;
  logic                              valid_q, valid_d;

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    top_d   = top_q;
    count_d = count_q;
    valid_d = valid_q;
    if (obs_i) begin
      if (restart_i || !valid_q) begin
        // First point of a cloud defines every bound.
        lo_d    = point_i;
        hi_d    = point_i;
        top_d   = '0;
        count_d = INDEX_BITS'(1);
        valid_d = 1'b1;
      end else begin
        for (int a = 0; a < NA; a++) begin
          if ($signed(point_i[a]) < $signed(lo_q[a])) lo_d[a] = point_i[a];
          // Strict compare: the earliest point keeps the peak on a tie.
          if ($signed(point_i[a]) > $signed(hi_q[a])) begin
            hi_d[a]  = point_i[a];
            top_d[a] = count_q;
          end
        end
        count_d = count_q + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hi_q    <= '0;
      top_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      top_q   <= top_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  assign lo_o    = lo_q;
  assign hi_o    = hi_q;
  assign top_o   = top_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/core/point_bounds_and_normalize_unit.sv
// Top level of the point bounds and normalize unit.
`timescale 1ns / 1ps
// Tracks per-axis bounds of 3D points in signed Q16.16 and maps points into
// unsigned Q16.16 over 0..scale_factor. An observe beat (kind 0) updates the
// running min, max and first-peak index of each axis; starts_cloud restarts
// tracking at that point as index 0. A normalize beat (kind 1) returns
// (v - min) * scale / (max - min) per axis, truncated, saturated to
// 0..scale << 16, and 0 on a flat axis or before any point. Every beat
// returns one result carrying the bounds after it. One item is in work at a
// time. An observe beat passes through the observe and emit states. A
// normalize beat passes through prep for each axis, and through mul and div
// as well for each axis that needs a division, before emit; the division
// uses the single bit-serial divider, shared by the three axes, which yields
// one quotient bit a cycle for 32 bits. The result becomes valid as the unit
// returns to idle. It sits in an output register, so the next beat is
// accepted while a finished result still waits; emit holds while that result
// is stalled. scale_factor is to be written through cfg_* only while the
// unit is idle; the unit itself does not enforce this.
module point_bounds_and_normalize_unit #(
  parameter int INDEX_BITS = pbn_pkg::DEF_INDEX_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbn_pkg::SCALE_BITS-1:0]    cfg_data_i,
  // point beats in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pbn_pkg::in_beat_t                 in_beat_i,
  // result beats out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pbn_pkg::out_beat_t                out_beat_o
);

  localparam int NA        = pbn_pkg::NUM_AXES;
  localparam int AB        = pbn_pkg::AXIS_BITS;
  localparam int CB        = pbn_pkg::COORD_BITS;
  localparam int SB        = pbn_pkg::SCALE_BITS;
  localparam int PB        = pbn_pkg::PROD_BITS;
  localparam int DB        = pbn_pkg::DIV_BITS;
  localparam int PeakBits  = pbn_pkg::PEAK_BITS;
  localparam int FracBits  = CB - SB;

  pbn_pkg::state_e                 state_q, state_d;
  logic [AB-1:0]                   axis_q, axis_d;
  pbn_pkg::in_beat_t               item_q, item_d;
  pbn_pkg::coord_vec_t             norm_q, norm_d;
  logic [CB-1:0]                   dist_q, dist_d;
  logic [CB-1:0]                   range_q, range_d;
  logic [SB-1:0]                   scale_q;
  pbn_pkg::out_beat_t              out_q, out_d;
  logic                            out_valid_q;

  logic                            in_accept;
  logic                            out_load;
  logic                            obs_en;
  logic                            div_start;
  logic                            div_done;
  logic [DB-1:0]                   quotient;
  logic [PB-1:0]                   prod;

  pbn_pkg::coord_vec_t             point;
  pbn_pkg::coord_vec_t             lo, hi;
  logic [NA-1:0][INDEX_BITS-1:0]   top;
  logic                            bounds_valid;

  logic [CB-1:0]                   v_sel, lo_sel, hi_sel;
  logic [CB:0]                     dist_w, range_w;
  logic                            flat_or_empty;
  logic                            at_or_below;
  logic                            saturate;
  logic [CB-1:0]                   full_scale;

  // --------------------------------------------------------------------
  // Configuration: the single register, always ready.
  // --------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= pbn_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  assign full_scale = {scale_q, FracBits'(0)};

  // --------------------------------------------------------------------
  // Bounds tracker.
  // --------------------------------------------------------------------
  assign point[0] = item_q.coord_x;
  assign point[1] = item_q.coord_y;
  assign point[2] = item_q.coord_z;

  pbn_tracker #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .obs_i     (obs_en),
    .restart_i (item_q.starts_cloud),
    .point_i   (point),
    .lo_o      (lo),
    .hi_o      (hi),
    .top_o     (top),
    .valid_o   (bounds_valid)
  );

  // --------------------------------------------------------------------
  // Per-axis preparation: pick the axis, form distance and range, and
  // sort out the cases that need no division.
  // --------------------------------------------------------------------
  always_comb begin
    case (axis_q)
      AB'(0):  begin v_sel = point[0]; lo_sel = lo[0]; hi_sel = hi[0]; end
      AB'(1):  begin v_sel = point[1]; lo_sel = lo[1]; hi_sel = hi[1]; end
      default: begin v_sel = point[2]; lo_sel = lo[2]; hi_sel = hi[2]; end
    endcase
  end

  assign dist_w  = {v_sel[CB-1], v_sel} - {lo_sel[CB-1], lo_sel};
  assign range_w = {hi_sel[CB-1], hi_sel} - {lo_sel[CB-1], lo_sel};

  // Flat axis, inverted bounds or no point yet: zero.
  assign flat_or_empty = !bounds_valid || range_w[CB] || (range_w == '0);
  // Coordinate at or below the minimum: zero.
  assign at_or_below   = dist_w[CB] || (dist_w == '0);
  // Coordinate at or above the maximum: full scale.
  assign saturate      = ($signed(dist_w) >= $signed(range_w));

  // Multiplier feeds the divider registers directly: dist * scale, then
  // the << 16 falls out of where the product bits are placed.
  assign prod = PB'(dist_q) * PB'(scale_q);

  pbn_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_hi_i   (prod[PB-1:PB-DB]),
    .num_lo_i   ({prod[PB-DB-1:0], (2*DB-PB)'(0)}),
    .divisor_i  (range_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // --------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    item_d     = item_q;
    norm_d     = norm_q;
    dist_d     = dist_q;
    range_d    = range_q;
    in_stall_o = 1'b1;
    obs_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      pbn_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_beat_i;
          norm_d = '0;
          axis_d = '0;
          state_d = (in_beat_i.kind == pbn_pkg::KIND_NORMALIZE) ?
                    pbn_pkg::ST_PREP : pbn_pkg::ST_OBSERVE;
        end
      end

      pbn_pkg::ST_OBSERVE: begin
        obs_en  = 1'b1;
        state_d = pbn_pkg::ST_EMIT;
      end

      pbn_pkg::ST_PREP: begin
        if (flat_or_empty || at_or_below || saturate) begin
          norm_d[axis_q] = (flat_or_empty || at_or_below) ? '0 : full_scale;
          if (axis_q == AB'(NA - 1)) begin
            state_d = pbn_pkg::ST_EMIT;
          end else begin
            axis_d = axis_q + AB'(1);
          end
        end else begin
          dist_d  = dist_w[CB-1:0];
          range_d = range_w[CB-1:0];
          state_d = pbn_pkg::ST_MUL;
        end
      end

      pbn_pkg::ST_MUL: begin
        div_start = 1'b1;
        state_d   = pbn_pkg::ST_DIV;
      end

      pbn_pkg::ST_DIV: begin
        if (div_done) begin
          norm_d[axis_q] = quotient;
          if (axis_q == AB'(NA - 1)) begin
            state_d = pbn_pkg::ST_EMIT;
          end else begin
            axis_d  = axis_q + AB'(1);
            state_d = pbn_pkg::ST_PREP;
          end
        end
      end

      pbn_pkg::ST_EMIT: begin
        // Hold until the output register is free or drains this cycle.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pbn_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pbn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbn_pkg::ST_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    norm_q  <= norm_d;
    dist_q  <= dist_d;
    range_q <= range_d;
  end

  // --------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------
  always_comb begin
    out_d              = out_q;
    out_d.norm_x       = norm_q[0];
    out_d.norm_y       = norm_q[1];
    out_d.norm_z       = norm_q[2];
    out_d.min_x        = lo[0];
    out_d.min_y        = lo[1];
    out_d.min_z        = lo[2];
    out_d.max_x        = hi[0];
    out_d.max_y        = hi[1];
    out_d.max_z        = hi[2];
    out_d.peak_x_index = PeakBits'(top[0]);
    out_d.peak_y_index = PeakBits'(top[1]);
    out_d.peak_z_index = PeakBits'(top[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // --------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------
`include "point_bounds_and_normalize_unit_assert.svh"

  `PBN_ASSERT_IMPL(a_load_from_emit, $rose(out_valid_q), $past(state_q) == pbn_pkg::ST_EMIT, "result loaded outside emit")
  `PBN_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == pbn_pkg::ST_DIV, "divider finished while not awaited")
  `PBN_ASSERT_IMPL(a_norm_in_range, out_valid_q, (out_q.norm_x <= full_scale) && (out_q.norm_y <= full_scale) && (out_q.norm_z <= full_scale), "normalized value above full scale")
  `PBN_ASSERT_IMPL(a_bounds_ordered, bounds_valid, ($signed(lo[0]) <= $signed(hi[0])) && ($signed(lo[1]) <= $signed(hi[1])) && ($signed(lo[2]) <= $signed(hi[2])), "tracked minimum above maximum")
  `PBN_ASSERT_NEXT(a_busy_after_accept, in_accept, state_q != pbn_pkg::ST_IDLE, "accepted beat not taken into work")

endmodule
